### rtl/pqus_pkg.sv
// Package for the priority queue with undo stack.
// Holds field widths, command and result types, action and status codes and cell controls.
// No dependencies.
package pqus_pkg;

    localparam int ID_W            = 16;
    localparam int PRIO_W          = 3;
    localparam int COUNT_W         = 5;
    localparam int DEF_CAPACITY    = 16;
    localparam int DEF_ID_BITS     = 16;

    typedef logic [PRIO_W-1:0] t_prio;

    typedef enum logic [1:0] {
        ACT_ADD      = 2'd0,
        ACT_COMPLETE = 2'd1,
        ACT_UNDO     = 2'd2,
        ACT_NONE     = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_QEMPTY = 2'd1,
        ST_SEMPTY = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    typedef struct packed {
        t_action           action;
        logic [ID_W-1:0]   task_id;
        t_prio             task_priority;
    } t_cmd;

    typedef struct packed {
        t_status              status;
        logic [ID_W-1:0]      moved_id;
        t_prio                moved_priority;
        logic [COUNT_W-1:0]   pending_count;
        logic [COUNT_W-1:0]   completed_count;
    } t_res;

    typedef enum logic [1:0] {
        Q_HOLD   = 2'd0,
        Q_INSERT = 2'd1,
        Q_POP    = 2'd2,
        Q_PUSH   = 2'd3
    } t_qop;

    typedef enum logic [1:0] {
        S_HOLD = 2'd0,
        S_PUSH = 2'd1,
        S_POP  = 2'd2
    } t_sop;

    typedef struct packed {
        t_qop  op;
        t_prio prio;
    } t_qctl;

endpackage

### rtl/pqus_qcell.sv
// One cell of the sorted pending queue.
// Compares its entry to the inserted priority and shifts with its neighbors.
// Depends on pqus_pkg.
module pqus_qcell
    import pqus_pkg::*;
#(
    parameter int ID_BITS = DEF_ID_BITS
) (
    input  logic               i_clk,
    input  t_qctl              i_ctl,
    input  logic [ID_BITS-1:0] i_new_id,
    input  logic               i_occupied,
    input  logic               i_left_ge,
    input  logic [ID_BITS-1:0] i_left_id,
    input  t_prio              i_left_prio,
    input  logic [ID_BITS-1:0] i_right_id,
    input  t_prio              i_right_prio,
    output logic               o_ge,
    output logic [ID_BITS-1:0] o_id,
    output t_prio              o_prio
);

    logic [ID_BITS-1:0] r_id;
    logic [ID_BITS-1:0] n_id;
    t_prio              r_prio;
    t_prio              n_prio;

    // high only while this cell and every cell ahead of it rank at or above the new entry
    assign o_ge   = i_left_ge && i_occupied && (r_prio >= i_ctl.prio);
    assign o_id   = r_id;
    assign o_prio = r_prio;

    always_comb begin
        n_id   = r_id;
        n_prio = r_prio;
        case (i_ctl.op)
            Q_INSERT: begin
                if (!o_ge) begin
                    if (i_left_ge) begin
                        n_id   = i_new_id;
                        n_prio = i_ctl.prio;
                    end else begin
                        n_id   = i_left_id;
                        n_prio = i_left_prio;
                    end
                end
            end
            Q_POP: begin
                n_id   = i_right_id;
                n_prio = i_right_prio;
            end
            Q_PUSH: begin
                n_id   = i_left_id;
                n_prio = i_left_prio;
            end
            default: begin
                n_id   = r_id;
                n_prio = r_prio;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_id   <= n_id;
        r_prio <= n_prio;
    end

endmodule

### rtl/pqus_scell.sv
// One cell of the completed stack, top at the first cell.
// Shifts toward the tail on push and toward the top on pop.
// Depends on pqus_pkg.
module pqus_scell
    import pqus_pkg::*;
#(
    parameter int ID_BITS = DEF_ID_BITS
) (
    input  logic               i_clk,
    input  t_sop               i_op,
    input  logic [ID_BITS-1:0] i_left_id,
    input  t_prio              i_left_prio,
    input  logic [ID_BITS-1:0] i_right_id,
    input  t_prio              i_right_prio,
    output logic [ID_BITS-1:0] o_id,
    output t_prio              o_prio
);

    logic [ID_BITS-1:0] r_id;
    logic [ID_BITS-1:0] n_id;
    t_prio              r_prio;
    t_prio              n_prio;

    assign o_id   = r_id;
    assign o_prio = r_prio;

    always_comb begin
        case (i_op)
            S_PUSH: begin
                n_id   = i_left_id;
                n_prio = i_left_prio;
            end
            S_POP: begin
                n_id   = i_right_id;
                n_prio = i_right_prio;
            end
            default: begin
                n_id   = r_id;
                n_prio = r_prio;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_id   <= n_id;
        r_prio <= n_prio;
    end

endmodule

### rtl/priority_queue_with_undo_stack.sv
// Top level of the priority queue with undo stack.
// Builds the queue and stack cell chains and the command decode.
// Depends on pqus_pkg, pqus_qcell and pqus_scell.
//
// One command is taken in every clock cycle; busy stays low. Its result
// appears on o_res with o_done high for exactly one cycle, the cycle after
// the command transfer, and must be taken then. The queue cells compare
// their priority to the new entry and shift in the same cycle, so an
// insert lands at any depth at once. CAPACITY bounds pending and completed
// entries together.
module priority_queue_with_undo_stack
    import pqus_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY,
    parameter int ID_BITS  = DEF_ID_BITS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_cmd i_cmd,
    output logic busy,
    output logic o_done,
    output t_res o_res
);

    localparam int FW = $clog2(CAPACITY + 1);

    logic [FW-1:0]      r_pfill;
    logic [FW-1:0]      n_pfill;
    logic [FW-1:0]      r_cfill;
    logic [FW-1:0]      n_cfill;
    logic               r_done;
    t_res               r_res;
    t_res               n_res;
    t_qctl              w_qctl;
    t_sop               w_sop;
    logic               w_take;
    logic               w_full;
    logic [ID_BITS-1:0] w_new_id;

    logic [ID_BITS-1:0] w_qid   [CAPACITY];
    t_prio              w_qprio [CAPACITY];
    logic               w_qge   [CAPACITY];
    logic [ID_BITS-1:0] w_sid   [CAPACITY];
    t_prio              w_sprio [CAPACITY];

    assign busy     = 1'b0;
    assign w_take   = start && !busy;
    assign w_new_id = ID_BITS'(i_cmd.task_id);
    assign w_full   = ((FW+1)'(r_pfill) + (FW+1)'(r_cfill)) >= (FW+1)'(CAPACITY);

    always_comb begin
        w_qctl.op   = Q_HOLD;
        w_qctl.prio = i_cmd.task_priority;
        w_sop       = S_HOLD;
        n_pfill     = r_pfill;
        n_cfill     = r_cfill;
        n_res       = '0;
        n_res.status = ST_OK;
        if (w_take) begin
            case (i_cmd.action)
                ACT_ADD: begin
                    if (w_full) begin
                        n_res.status = ST_FULL;
                    end else begin
                        w_qctl.op            = Q_INSERT;
                        n_pfill              = r_pfill + 1'b1;
                        n_res.moved_id       = ID_W'(w_new_id);
                        n_res.moved_priority = i_cmd.task_priority;
                    end
                end
                ACT_COMPLETE: begin
                    if (r_pfill == '0) begin
                        n_res.status = ST_QEMPTY;
                    end else begin
                        w_qctl.op            = Q_POP;
                        w_sop                = S_PUSH;
                        n_pfill              = r_pfill - 1'b1;
                        n_cfill              = r_cfill + 1'b1;
                        n_res.moved_id       = ID_W'(w_qid[0]);
                        n_res.moved_priority = w_qprio[0];
                    end
                end
                ACT_UNDO: begin
                    if (r_cfill == '0) begin
                        n_res.status = ST_SEMPTY;
                    end else begin
                        w_qctl.op            = Q_PUSH;
                        w_sop                = S_POP;
                        n_pfill              = r_pfill + 1'b1;
                        n_cfill              = r_cfill - 1'b1;
                        n_res.moved_id       = ID_W'(w_sid[0]);
                        n_res.moved_priority = w_sprio[0];
                    end
                end
                default: begin
                    n_res.status = ST_OK;
                end
            endcase
        end
        n_res.pending_count   = COUNT_W'(n_pfill);
        n_res.completed_count = COUNT_W'(n_cfill);
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic               w_occ;
            logic               w_lge;
            logic [ID_BITS-1:0] w_qlid;
            t_prio              w_qlprio;
            logic [ID_BITS-1:0] w_qrid;
            t_prio              w_qrprio;
            logic [ID_BITS-1:0] w_slid;
            t_prio              w_slprio;
            logic [ID_BITS-1:0] w_srid;
            t_prio              w_srprio;

            assign w_occ = r_pfill > FW'(gi);

            if (gi == 0) begin : g_head
                assign w_lge    = 1'b1;
                assign w_qlid   = w_sid[0];
                assign w_qlprio = w_sprio[0];
                assign w_slid   = w_qid[0];
                assign w_slprio = w_qprio[0];
            end else begin : g_body
                assign w_lge    = w_qge[gi-1];
                assign w_qlid   = w_qid[gi-1];
                assign w_qlprio = w_qprio[gi-1];
                assign w_slid   = w_sid[gi-1];
                assign w_slprio = w_sprio[gi-1];
            end

            if (gi == CAPACITY - 1) begin : g_tail
                assign w_qrid   = '0;
                assign w_qrprio = '0;
                assign w_srid   = '0;
                assign w_srprio = '0;
            end else begin : g_inner
                assign w_qrid   = w_qid[gi+1];
                assign w_qrprio = w_qprio[gi+1];
                assign w_srid   = w_sid[gi+1];
                assign w_srprio = w_sprio[gi+1];
            end

            pqus_qcell #(
                .ID_BITS(ID_BITS)
            ) u_qcell (
                .i_clk        (i_clk),
                .i_ctl        (w_qctl),
                .i_new_id     (w_new_id),
                .i_occupied   (w_occ),
                .i_left_ge    (w_lge),
                .i_left_id    (w_qlid),
                .i_left_prio  (w_qlprio),
                .i_right_id   (w_qrid),
                .i_right_prio (w_qrprio),
                .o_ge         (w_qge[gi]),
                .o_id         (w_qid[gi]),
                .o_prio       (w_qprio[gi])
            );

            pqus_scell #(
                .ID_BITS(ID_BITS)
            ) u_scell (
                .i_clk        (i_clk),
                .i_op         (w_sop),
                .i_left_id    (w_slid),
                .i_left_prio  (w_slprio),
                .i_right_id   (w_srid),
                .i_right_prio (w_srprio),
                .o_id         (w_sid[gi]),
                .o_prio       (w_sprio[gi])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pfill <= '0;
            r_cfill <= '0;
            r_done  <= 1'b0;
        end else begin
            r_pfill <= n_pfill;
            r_cfill <= n_cfill;
            r_done  <= w_take;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

### rtl/pqus_chk.sv
// Port-level checker for the priority queue with undo stack, bound to the top level.
// Depends on pqus_pkg and priority_queue_with_undo_stack.
module pqus_chk
    import pqus_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_done,
    input t_res o_res
);

    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_done)
        else $error("transfer without result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |=> !o_done)
        else $error("result without transfer");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res.status != ST_OK) |->
            (o_res.moved_id == '0 && o_res.moved_priority == '0))
        else $error("failed action reports an entry");

    a_capacity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (int'(o_res.pending_count) + int'(o_res.completed_count) <= CAPACITY))
        else $error("counts exceed capacity");

    a_qempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res.status == ST_QEMPTY) |-> (o_res.pending_count == '0))
        else $error("queue empty with pending entries");

endmodule

bind priority_queue_with_undo_stack pqus_chk #(.CAPACITY(CAPACITY)) u_pqus_chk (.*);

### tb/priority_queue_with_undo_stack_tb.sv
// Testbench for priority_queue_with_undo_stack: directed and random add, complete and undo
// traffic, checked against a cycle-free model of the sorted queue and the completed stack.
// Depends on pqus_pkg and the priority_queue_with_undo_stack RTL.
`timescale 1ns / 100ps

module priority_queue_with_undo_stack_tb;
    import pqus_pkg::*;

    localparam int CAP       = DEF_CAPACITY;
    localparam int N_RANDOM  = 400;
    localparam int LIMIT     = 200000;
    localparam int MODE_FILL  = 0;
    localparam int MODE_DRAIN = 1;
    localparam int MODE_UNDO  = 2;
    localparam int MODE_MIX   = 3;

    typedef struct packed {
        logic [ID_W-1:0] id;
        t_prio           prio;
    } pq_entry_t;

    class pqus_scoreboard;
        pq_entry_t q_ent[CAP];
        pq_entry_t s_ent[CAP];
        int        q_fill;
        int        s_fill;
        t_res      awaited[$];
        int        errors;
        int        n_checked;
        int        n_status[4];
        int        peak_fill;

        function new();
            q_fill    = 0;
            s_fill    = 0;
            errors    = 0;
            n_checked = 0;
            peak_fill = 0;
            foreach (n_status[k]) n_status[k] = 0;
        endfunction

        function void note_cmd(t_cmd c);
            t_res      r;
            pq_entry_t e;
            int        pos;
            r        = '0;
            r.status = ST_OK;
            case (c.action)
                ACT_ADD: begin
                    if (q_fill + s_fill >= CAP) begin
                        r.status = ST_FULL;
                    end else begin
                        e.id   = c.task_id;
                        e.prio = c.task_priority;
                        pos    = 0;
                        while (pos < q_fill && q_ent[pos].prio >= e.prio) pos++;
                        for (int i = q_fill; i > pos; i--) q_ent[i] = q_ent[i-1];
                        q_ent[pos]       = e;
                        q_fill++;
                        r.moved_id       = e.id;
                        r.moved_priority = e.prio;
                    end
                end
                ACT_COMPLETE: begin
                    if (q_fill == 0) begin
                        r.status = ST_QEMPTY;
                    end else begin
                        e = q_ent[0];
                        for (int i = 1; i < q_fill; i++) q_ent[i-1] = q_ent[i];
                        q_fill--;
                        s_ent[s_fill]    = e;
                        s_fill++;
                        r.moved_id       = e.id;
                        r.moved_priority = e.prio;
                    end
                end
                ACT_UNDO: begin
                    if (s_fill == 0) begin
                        r.status = ST_SEMPTY;
                    end else begin
                        s_fill--;
                        e = s_ent[s_fill];
                        for (int i = q_fill; i > 0; i--) q_ent[i] = q_ent[i-1];
                        q_ent[0]         = e;
                        q_fill++;
                        r.moved_id       = e.id;
                        r.moved_priority = e.prio;
                    end
                end
                default: begin
                end
            endcase
            r.pending_count   = COUNT_W'(q_fill);
            r.completed_count = COUNT_W'(s_fill);
            n_status[r.status]++;
            if (q_fill + s_fill > peak_fill) peak_fill = q_fill + s_fill;
            awaited.push_back(r);
        endfunction

        function void cmp_field(string fld, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fld, want, got);
                errors++;
            end
        endfunction

        function void check_res(t_res r);
            t_res e;
            if (awaited.size() == 0) begin
                $display("%0t: result with nothing expected, actual %h", $time, r);
                errors++;
            end else begin
                e = awaited.pop_front();
                n_checked++;
                cmp_field("status", 32'(e.status), 32'(r.status));
                cmp_field("moved_id", 32'(e.moved_id), 32'(r.moved_id));
                cmp_field("moved_priority", 32'(e.moved_priority), 32'(r.moved_priority));
                cmp_field("pending_count", 32'(e.pending_count), 32'(r.pending_count));
                cmp_field("completed_count", 32'(e.completed_count),
                          32'(r.completed_count));
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic start;
    t_cmd i_cmd;
    logic busy;
    logic o_done;
    t_res o_res;
    int   cycles = 0;
    int   burst_left = 0;

    pqus_scoreboard sb = new();

    priority_queue_with_undo_stack u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_cmd   (i_cmd),
        .busy    (busy),
        .o_done  (o_done),
        .o_res   (o_res)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("[priority_queue_with_undo_stack] ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done) sb.check_res(o_res);
            if (start && !busy) sb.note_cmd(i_cmd);
        end
    end

    function automatic t_cmd mk_cmd(t_action a, logic [ID_W-1:0] id, t_prio p);
        t_cmd c;
        c.action        = a;
        c.task_id       = id;
        c.task_priority = p;
        return c;
    endfunction

    function automatic t_action pick_action(int m);
        int r;
        int a_w;
        int c_w;
        int u_w;
        r = $urandom_range(0, 99);
        case (m)
            MODE_FILL:  begin a_w = 75; c_w = 10; u_w = 10; end
            MODE_DRAIN: begin a_w = 15; c_w = 70; u_w = 10; end
            MODE_UNDO:  begin a_w = 15; c_w = 25; u_w = 55; end
            default:    begin a_w = 34; c_w = 30; u_w = 30; end
        endcase
        if (r < a_w) return ACT_ADD;
        if (r < a_w + c_w) return ACT_COMPLETE;
        if (r < a_w + c_w + u_w) return ACT_UNDO;
        return ACT_NONE;
    endfunction

    task automatic send_cmd(t_cmd c);
        logic [$bits(t_cmd)-1:0] noise;
        int                      gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? 48 : $urandom_range(1, 10);
            gap        = $urandom_range(0, 5);
            if (gap != 0) begin
                noise = $bits(t_cmd)'($urandom);
                start <= 1'b0;
                i_cmd <= noise;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        start <= 1'b1;
        i_cmd <= c;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    initial begin
        t_cmd c;
        int   n_items;
        int   m;
        int   len;
        int   k;

        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_cmd   <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_cmd(mk_cmd(ACT_COMPLETE, 16'h0000, 3'd0));
        send_cmd(mk_cmd(ACT_UNDO, 16'h0000, 3'd0));
        send_cmd(mk_cmd(ACT_NONE, 16'hFFFF, 3'd7));
        send_cmd(mk_cmd(ACT_ADD, 16'h0000, 3'd0));
        send_cmd(mk_cmd(ACT_COMPLETE, 16'hFFFF, 3'd7));
        send_cmd(mk_cmd(ACT_ADD, 16'hFFFF, 3'd7));
        send_cmd(mk_cmd(ACT_ADD, 16'h1234, 3'd7));
        send_cmd(mk_cmd(ACT_ADD, 16'h00A5, 3'd3));
        // low-priority entry returns to the head on undo
        send_cmd(mk_cmd(ACT_UNDO, 16'h0000, 3'd0));
        send_cmd(mk_cmd(ACT_COMPLETE, 16'h0000, 3'd0));
        send_cmd(mk_cmd(ACT_COMPLETE, 16'h0000, 3'd0));
        send_cmd(mk_cmd(ACT_COMPLETE, 16'h0000, 3'd0));
        send_cmd(mk_cmd(ACT_UNDO, 16'h0000, 3'd0));
        // fill the store, then overflow it
        for (k = 0; k < 13; k++) begin
            send_cmd(mk_cmd(ACT_ADD, 16'(k * 16'h1357 + 16'h8001), 3'(k)));
        end

        n_items = 0;
        while (n_items < N_RANDOM) begin
            m   = $urandom_range(MODE_FILL, MODE_MIX);
            len = $urandom_range(8, 40);
            repeat (len) begin
                c.action = pick_action(m);
                if ($urandom_range(0, 9) == 0) begin
                    c.task_id = ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
                end else begin
                    c.task_id = 16'($urandom);
                end
                c.task_priority = 3'($urandom_range(0, 7));
                send_cmd(c);
                if (c.action != ACT_NONE) n_items++;
            end
        end
        start <= 1'b0;

        while (sb.awaited.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        $display("Checked %0d results: %0d ok, %0d store full, %0d queue empty, %0d stack empty.",
                 sb.n_checked, sb.n_status[ST_OK], sb.n_status[ST_FULL],
                 sb.n_status[ST_QEMPTY], sb.n_status[ST_SEMPTY]);
        $display("Peak store occupancy %0d of %0d entries.", sb.peak_fill, CAP);
        if (sb.errors == 0) begin
            $display("[priority_queue_with_undo_stack] OK");
        end else begin
            $display("[priority_queue_with_undo_stack] ERROR");
        end
        $finish;
    end

endmodule

### sim.f
rtl/pqus_pkg.sv
rtl/pqus_qcell.sv
rtl/pqus_scell.sv
rtl/priority_queue_with_undo_stack.sv
rtl/pqus_chk.sv
tb/priority_queue_with_undo_stack_tb.sv
